// File: design/zrld_pkg.sv
`timescale 1ns / 1ps

package zrld_pkg;

    localparam int DIM_W       = 11;
    localparam int RUN_W       = 21;
    localparam int LINE_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0]  MAX_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]  MAX_HEIGHT = 11'd1024;
    localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [LINE_W-1:0] HDR_BYTES  = 16'd2;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       has_run;
        logic       last;
        logic [7:0] value;
        logic [7:0] count;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_LEN_LO = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_COUNT  = 4'b1000
    } phase_t;

endpackage

// File: design/zero_run_line_decoder.sv
`timescale 1ns / 1ps
// A run passes through the command queue and the output register before it appears on
// the output; the closing pad run follows when the last byte also yields a run.
// Throughput: one byte per cycle while the queue is not full; the back end drains one
// run per cycle while run_ready allows; a four-entry command queue absorbs the pad run.
// Reset: async, active low; parser to PH_LEN_LO; counters, queue pointers, config to 0.
module zero_run_line_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [zrld_pkg::DIM_W-1:0] cfg_data,
    input  logic                       byte_valid,
    output logic                       byte_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       run_valid,
    input  logic                       run_ready,
    output logic [7:0]                 pixel_value,
    output logic [zrld_pkg::RUN_W-1:0] run_length,
    output logic                       frame_end
);

    logic [zrld_pkg::DIM_W-1:0] width_reg, width_next;
    logic [zrld_pkg::DIM_W-1:0] height_reg, height_next;
    logic [zrld_pkg::DIM_W-1:0] eff_width;
    logic [zrld_pkg::DIM_W-1:0] eff_height;
    logic                       accept;
    logic                       push;
    logic                       pop;
    logic                       empty;
    logic                       full;
    zrld_pkg::cmd_t             push_cmd;
    zrld_pkg::cmd_t             head_cmd;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;
    assign eff_width  = (width_reg < zrld_pkg::MAX_WIDTH) ? width_reg : zrld_pkg::MAX_WIDTH;
    assign eff_height = (height_reg < zrld_pkg::MAX_HEIGHT) ? height_reg : zrld_pkg::MAX_HEIGHT;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                zrld_pkg::REG_FRAME_WIDTH:  width_next  = cfg_data;
                zrld_pkg::REG_FRAME_HEIGHT: height_next = cfg_data;
                default:                    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    zrld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .eff_height (eff_height),
        .push       (push),
        .cmd        (push_cmd)
    );

    zrld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    zrld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .head_cmd    (head_cmd),
        .empty       (empty),
        .pop         (pop),
        .run_valid   (run_valid),
        .run_ready   (run_ready),
        .pixel_value (pixel_value),
        .run_length  (run_length),
        .frame_end   (frame_end)
    );

endmodule

// File: design/zrld_front.sv
`timescale 1ns / 1ps

module zrld_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    input  logic [zrld_pkg::DIM_W-1:0] eff_height,
    output logic                       push,
    output zrld_pkg::cmd_t             cmd
);

    zrld_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                     len_lo_reg, len_lo_next;
    logic [zrld_pkg::LINE_W-1:0]    left_reg, left_next;
    logic [zrld_pkg::DIM_W-1:0]     lines_reg, lines_next;
    logic [zrld_pkg::LINE_W-1:0]    hdr_word;
    logic [zrld_pkg::LINE_W-1:0]    left_dec;

    always_comb
    begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        lines_next  = lines_reg;
        hdr_word    = {data_byte, len_lo_reg};
        left_dec    = left_reg - 1'b1;
        cmd.has_run = 1'b0;
        cmd.last    = last_byte;
        cmd.value   = data_byte;
        cmd.count   = 8'd1;
        unique case (phase_reg)
            zrld_pkg::PH_LEN_LO:
            begin
                if (lines_reg < eff_height)
                begin
                    len_lo_next = data_byte;
                    phase_next  = zrld_pkg::PH_LEN_HI;
                end
            end
            zrld_pkg::PH_LEN_HI:
            begin
                lines_next = lines_reg + 1'b1;
                if (hdr_word > zrld_pkg::HDR_BYTES)
                begin
                    left_next  = hdr_word - zrld_pkg::HDR_BYTES;
                    phase_next = zrld_pkg::PH_BODY;
                end
                else
                begin
                    left_next  = '0;
                    phase_next = zrld_pkg::PH_LEN_LO;
                end
            end
            zrld_pkg::PH_BODY:
            begin
                left_next = left_dec;
                if (data_byte != 8'd0)
                begin
                    cmd.has_run = 1'b1;
                    if (left_dec == '0)
                        phase_next = zrld_pkg::PH_LEN_LO;
                end
                else
                begin
                    phase_next = (left_dec == '0) ? zrld_pkg::PH_LEN_LO : zrld_pkg::PH_COUNT;
                end
            end
            zrld_pkg::PH_COUNT:
            begin
                left_next   = left_dec;
                cmd.has_run = 1'b1;
                cmd.value   = 8'd0;
                cmd.count   = data_byte;
                phase_next  = (left_dec == '0) ? zrld_pkg::PH_LEN_LO : zrld_pkg::PH_BODY;
            end
            default:
            begin
                phase_next = zrld_pkg::PH_LEN_LO;
            end
        endcase
        if (last_byte)
        begin
            phase_next  = zrld_pkg::PH_LEN_LO;
            len_lo_next = '0;
            left_next   = '0;
            lines_next  = '0;
        end
        push = accept && (cmd.has_run || cmd.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= zrld_pkg::PH_LEN_LO;
            len_lo_reg <= '0;
            left_reg   <= '0;
            lines_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            left_reg   <= left_next;
            lines_reg  <= lines_next;
        end
    end

endmodule

// File: design/zrld_queue.sv
`timescale 1ns / 1ps

module zrld_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zrld_pkg::cmd_t push_cmd,
    input  logic           pop,
    output zrld_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);

    zrld_pkg::cmd_t                 slots_reg [zrld_pkg::QUEUE_DEPTH];
    logic [zrld_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [zrld_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [zrld_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == zrld_pkg::QCNT_W'(zrld_pkg::QUEUE_DEPTH));
    assign head_cmd = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/zrld_back.sv
`timescale 1ns / 1ps

module zrld_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [zrld_pkg::DIM_W-1:0] eff_width,
    input  logic [zrld_pkg::DIM_W-1:0] eff_height,
    input  zrld_pkg::cmd_t             head_cmd,
    input  logic                       empty,
    output logic                       pop,
    output logic                       run_valid,
    input  logic                       run_ready,
    output logic [7:0]                 pixel_value,
    output logic [zrld_pkg::RUN_W-1:0] run_length,
    output logic                       frame_end
);

    logic [2*zrld_pkg::DIM_W-1:0]  product;
    logic [zrld_pkg::RUN_W-1:0]    size_reg, size_next;
    logic [zrld_pkg::RUN_W-1:0]    emitted_reg, emitted_next;
    logic                          pad_pend_reg, pad_pend_next;
    logic                          valid_reg, valid_next;
    logic [7:0]                    pixel_reg, pixel_next;
    logic [zrld_pkg::RUN_W-1:0]    len_reg, len_next;
    logic                          end_reg, end_next;
    logic                          slot_free;
    logic [zrld_pkg::RUN_W-1:0]    room;
    logic [zrld_pkg::RUN_W-1:0]    want;
    logic [zrld_pkg::RUN_W-1:0]    clipped;

    assign slot_free   = !valid_reg || run_ready;
    assign pop         = slot_free && !pad_pend_reg && !empty;
    assign run_valid   = valid_reg;
    assign pixel_value = pixel_reg;
    assign run_length  = len_reg;
    assign frame_end   = end_reg;

    always_comb
    begin
        product   = eff_width * eff_height;
        size_next = (product > {1'b0, zrld_pkg::RUN_MAX})
                    ? zrld_pkg::RUN_MAX : product[zrld_pkg::RUN_W-1:0];
    end

    always_comb
    begin
        room          = (size_reg > emitted_reg) ? size_reg - emitted_reg : '0;
        want          = zrld_pkg::RUN_W'(head_cmd.count);
        clipped       = (want < room) ? want : room;
        emitted_next  = emitted_reg;
        pad_pend_next = pad_pend_reg;
        valid_next    = slot_free ? 1'b0 : valid_reg;
        pixel_next    = pixel_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        priority if (slot_free && pad_pend_reg)
        begin
            valid_next    = 1'b1;
            pixel_next    = 8'd0;
            len_next      = room;
            end_next      = 1'b1;
            emitted_next  = '0;
            pad_pend_next = 1'b0;
        end
        else if (pop)
        begin
            if (head_cmd.has_run && clipped != '0)
            begin
                valid_next    = 1'b1;
                pixel_next    = head_cmd.value;
                len_next      = clipped;
                end_next      = 1'b0;
                emitted_next  = emitted_reg + clipped;
                pad_pend_next = head_cmd.last;
            end
            else if (head_cmd.last)
            begin
                valid_next   = 1'b1;
                pixel_next   = 8'd0;
                len_next     = room;
                end_next     = 1'b1;
                emitted_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        len_reg   <= len_next;
        end_reg   <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= '0;
            emitted_reg  <= '0;
            pad_pend_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            size_reg     <= size_next;
            emitted_reg  <= emitted_next;
            pad_pend_reg <= pad_pend_next;
            valid_reg    <= valid_next;
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_BYTES   = 1300;
    localparam int CALM_BYTES     = 150;
    localparam int N_DIRECTED     = 35;

    typedef struct packed {
        logic [7:0]                 value;
        logic [zrld_pkg::RUN_W-1:0] len;
        logic                       fend;
    } run_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_WIDTH,
        ROW_HEIGHT
    } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [zrld_pkg::DIM_W-1:0] arg;
        logic                       last;
        logic                       typed;
        logic [7:0]                 px;
        logic [zrld_pkg::RUN_W-1:0] len;
        logic                       fend;
    } dir_row_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index   = zrld_pkg::REG_FRAME_WIDTH;
    logic [zrld_pkg::DIM_W-1:0]    cfg_data    = '0;
    logic                          byte_valid  = 1'b0;
    logic                          byte_ready;
    logic [7:0]                    data_byte   = '0;
    logic                          last_byte   = 1'b0;
    logic                          run_valid;
    logic                          run_ready   = 1'b0;
    logic [7:0]                    pixel_value;
    logic [zrld_pkg::RUN_W-1:0]    run_length;
    logic                          frame_end;

    // predictor state
    logic [zrld_pkg::DIM_W-1:0]    width_reg;
    logic [zrld_pkg::DIM_W-1:0]    height_reg;
    zrld_pkg::phase_t              dec_phase;
    logic [7:0]                    len_lo;
    logic [zrld_pkg::LINE_W-1:0]   bytes_left;
    logic [zrld_pkg::DIM_W-1:0]    lines_seen;
    logic [zrld_pkg::RUN_W-1:0]    px_out;

    run_t                 byte_runs[$];
    run_t                 expected_runs[$];

    int                   idle_pct      = 0;
    int                   stall_left    = 0;
    int                   quiet_cycles  = 0;
    int                   bytes_sent    = 0;
    int                   frames_sent   = 0;
    int                   runs_checked  = 0;
    int                   mismatches    = 0;
    int                   settings_used = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_BYTE,   11'h0FF, 1'b1, 1'b1, 8'd0,   21'd0,       1'b1},
        '{ROW_WIDTH,  11'd4,   1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_HEIGHT, 11'd2,   1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h005, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h007, 1'b0, 1'b1, 8'd7,   21'd1,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h003, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h001, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h05A, 1'b1, 1'b1, 8'd0,   21'd4,       1'b1},
        '{ROW_WIDTH,  11'd1024, 1'b0, 1'b0, 8'd0,  21'd0,       1'b0},
        '{ROW_HEIGHT, 11'd1024, 1'b0, 1'b0, 8'd0,  21'd0,       1'b0},
        '{ROW_BYTE,   11'h004, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h003, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h0FF, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h0FF, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h0FF, 1'b0, 1'b1, 8'd255, 21'd1,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b1, 1'b1, 8'd0,   21'd1048575, 1'b1},
        '{ROW_WIDTH,  11'd2,   1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_HEIGHT, 11'd2,   1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h005, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h009, 1'b0, 1'b1, 8'd9,   21'd1,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h005, 1'b0, 1'b1, 8'd0,   21'd3,       1'b0},
        '{ROW_BYTE,   11'h003, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h000, 1'b0, 1'b0, 8'd0,   21'd0,       1'b0},
        '{ROW_BYTE,   11'h033, 1'b1, 1'b1, 8'd0,   21'd0,       1'b1},
        '{ROW_BYTE,   11'h007, 1'b1, 1'b1, 8'd0,   21'd4,       1'b1}
    };

    zero_run_line_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .run_valid   (run_valid),
        .run_ready   (run_ready),
        .pixel_value (pixel_value),
        .run_length  (run_length),
        .frame_end   (frame_end)
    );

    always #10 clk = ~clk;

    function automatic logic [zrld_pkg::DIM_W-1:0] eff_height();
        return (height_reg < zrld_pkg::MAX_HEIGHT) ? height_reg : zrld_pkg::MAX_HEIGHT;
    endfunction

    function automatic logic [zrld_pkg::RUN_W-1:0] pixels_left();
        logic [63:0]                w64;
        logic [63:0]                h64;
        logic [63:0]                area;
        logic [zrld_pkg::RUN_W-1:0] total;
        w64   = (width_reg < zrld_pkg::MAX_WIDTH) ? 64'(width_reg) : 64'(zrld_pkg::MAX_WIDTH);
        h64   = 64'(eff_height());
        area  = w64 * h64;
        total = (area > 64'(zrld_pkg::RUN_MAX)) ? zrld_pkg::RUN_MAX
                                                 : area[zrld_pkg::RUN_W-1:0];
        return (px_out < total) ? total - px_out : '0;
    endfunction

    function automatic void clear_decoder();
        dec_phase  = zrld_pkg::PH_LEN_LO;
        len_lo     = '0;
        bytes_left = '0;
        lines_seen = '0;
        px_out     = '0;
    endfunction

    function automatic void clip_run(input logic [7:0] value,
                                     input logic [zrld_pkg::RUN_W-1:0] len);
        logic [zrld_pkg::RUN_W-1:0] room;
        logic [zrld_pkg::RUN_W-1:0] n;
        run_t                       r;
        room = pixels_left();
        n    = (len < room) ? len : room;
        if (n != '0)
        begin
            r.value   = value;
            r.len     = n;
            r.fend    = 1'b0;
            byte_runs = {byte_runs, r};
            px_out    = px_out + n;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [zrld_pkg::LINE_W-1:0] hdr_len;
        run_t                        pad;
        byte_runs.delete();
        unique case (dec_phase)
            zrld_pkg::PH_LEN_LO:
            begin
                if (lines_seen < eff_height())
                begin
                    len_lo    = b;
                    dec_phase = zrld_pkg::PH_LEN_HI;
                end
            end
            zrld_pkg::PH_LEN_HI:
            begin
                hdr_len    = {b, len_lo};
                lines_seen = lines_seen + 1'b1;
                if (hdr_len > zrld_pkg::HDR_BYTES)
                begin
                    bytes_left = hdr_len - zrld_pkg::HDR_BYTES;
                    dec_phase  = zrld_pkg::PH_BODY;
                end
                else
                begin
                    bytes_left = '0;
                    dec_phase  = zrld_pkg::PH_LEN_LO;
                end
            end
            zrld_pkg::PH_BODY:
            begin
                bytes_left = bytes_left - 1'b1;
                if (b != 8'd0)
                begin
                    clip_run(b, zrld_pkg::RUN_W'(1));
                    if (bytes_left == '0)
                        dec_phase = zrld_pkg::PH_LEN_LO;
                end
                else
                    dec_phase = (bytes_left == '0) ? zrld_pkg::PH_LEN_LO : zrld_pkg::PH_COUNT;
            end
            zrld_pkg::PH_COUNT:
            begin
                bytes_left = bytes_left - 1'b1;
                clip_run(8'd0, zrld_pkg::RUN_W'(b));
                dec_phase = (bytes_left == '0) ? zrld_pkg::PH_LEN_LO : zrld_pkg::PH_BODY;
            end
            default:
                dec_phase = zrld_pkg::PH_LEN_LO;
        endcase
        if (last)
        begin
            pad.value = 8'd0;
            pad.len   = pixels_left();
            pad.fend  = 1'b1;
            byte_runs = {byte_runs, pad};
            clear_decoder();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input run_t want);
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= last;
        do
            @(posedge clk);
        while (!byte_ready);
        decode_byte(b, last);
        if (typed)
            expected_runs = {expected_runs, want};
        else
            expected_runs = {expected_runs, byte_runs};
        bytes_sent++;
        if (last)
            frames_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [zrld_pkg::DIM_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == zrld_pkg::REG_FRAME_WIDTH)
            width_reg = d;
        else
            height_reg = d;
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_runs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed frames; some noise, cut-off data and trailing junk
    task automatic send_frame();
        int          kind;
        int          lines;
        int          body;
        int          keep;
        logic [15:0] hdr;
        logic [7:0]  frame_q[$];
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            repeat ($urandom_range(1, 20)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
        end
        else
        begin
            lines = (height_reg >= 1 && height_reg <= 8) ? int'(height_reg)
                                                         : int'($urandom_range(1, 6));
            repeat (lines)
            begin
                body = ($urandom_range(0, 12) == 0) ? 0 : int'($urandom_range(1, 12));
                hdr  = (body == 0) ? 16'($urandom_range(0, 2)) : 16'(body + 2);
                frame_q = {frame_q, hdr[7:0], hdr[15:8]};
                while (body > 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        frame_q = {frame_q, 8'h00};
                        body--;
                        if (body > 0)
                        begin
                            frame_q = {frame_q, ($urandom_range(0, 3) == 0) ?
                                       8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8))};
                            body--;
                        end
                    end
                    else
                    begin
                        frame_q = {frame_q, 8'($urandom_range(1, 255))};
                        body--;
                    end
                end
            end
            if (kind == 8 && frame_q.size() > 1)
            begin
                keep = int'($urandom_range(1, frame_q.size() - 1));
                while (frame_q.size() > keep)
                    void'(frame_q.pop_back());
            end
            if (kind == 9)
                frame_q = {frame_q, 8'($urandom_range(0, 255))};
            if (kind == 6)
                repeat ($urandom_range(1, 3)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
        end
        if (frame_q.size() == 0)
            frame_q = {frame_q, 8'($urandom_range(0, 255))};
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            run_ready  <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(0, 3);
            run_ready  <= 1'b0;
        end
        else
            run_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        run_t want;
        if (rst_n && run_valid && run_ready)
        begin
            runs_checked++;
            if (expected_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected run beat: value %0d length %0d end %0b",
                             pixel_value, run_length, frame_end);
            end
            else
            begin
                want = expected_runs.pop_front();
                if (pixel_value !== want.value || run_length !== want.len ||
                    frame_end !== want.fend)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("run %0d: expected value %0d length %0d end %0b,",
                                 runs_checked, want.value, want.len, want.fend);
                        $display("    got value %0d length %0d end %0b",
                                 pixel_value, run_length, frame_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (cfg_valid && cfg_ready) ||
            (run_valid && run_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        dir_row_t                   r;
        int                         pick;
        int                         phase_bytes;
        int                         calm_start;
        logic [zrld_pkg::DIM_W-1:0] w;
        logic [zrld_pkg::DIM_W-1:0] h;
        width_reg  = '0;
        height_reg = '0;
        calm_start = N_DIRECTED + RANDOM_BYTES - CALM_BYTES;
        clear_decoder();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 25;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            unique case (r.kind)
                ROW_WIDTH:
                begin
                    wait_idle();
                    write_reg(zrld_pkg::REG_FRAME_WIDTH, r.arg);
                    settings_used++;
                end
                ROW_HEIGHT:
                begin
                    wait_idle();
                    write_reg(zrld_pkg::REG_FRAME_HEIGHT, r.arg);
                end
                default:
                    send_byte(r.arg[7:0], r.last, r.typed, {r.px, r.len, r.fend});
            endcase
        end

        while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    w = 11'd1024;
                    h = 11'd1024;
                end
                1:
                begin
                    w = 11'd0;
                    h = zrld_pkg::DIM_W'($urandom_range(1, 6));
                end
                2:
                begin
                    w = zrld_pkg::DIM_W'($urandom_range(1, 16));
                    h = 11'd0;
                end
                3:
                begin
                    w = 11'd1023;
                    h = zrld_pkg::DIM_W'($urandom_range(1, 3));
                end
                4:
                begin
                    w = zrld_pkg::DIM_W'($urandom_range(0, 1024));
                    h = zrld_pkg::DIM_W'($urandom_range(1, 1024));
                end
                default:
                begin
                    w = zrld_pkg::DIM_W'($urandom_range(1, 16));
                    h = zrld_pkg::DIM_W'($urandom_range(1, 6));
                end
            endcase
            pick = $urandom_range(0, 3);
            if (pick != 1)
                write_reg(zrld_pkg::REG_FRAME_WIDTH, w);
            if (pick != 0)
            begin
                if (pick != 1)
                    wait_idle();
                write_reg(zrld_pkg::REG_FRAME_HEIGHT, h);
            end
            settings_used++;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (bytes_sent >= calm_start)
                idle_pct = 0;
            phase_bytes = bytes_sent + int'($urandom_range(60, 140));
            if (bytes_sent < calm_start && phase_bytes > calm_start)
                phase_bytes = calm_start;
            while (bytes_sent < phase_bytes)
                send_frame();
        end

        idle_pct = 0;
        wait_idle();
        $display("covered %0d bytes in %0d frames across %0d frame size settings",
                 bytes_sent, frames_sent, settings_used);
        $display("checked %0d runs, %0d mismatches", runs_checked, mismatches);
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
